// ===== sv/schroeder_reverb_defines.svh =====
// Assertion macros shared by the reverberator RTL.
`ifndef SCHROEDER_REVERB_DEFINES_SVH
`define SCHROEDER_REVERB_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define SR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("schroeder_reverb: assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define SR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("schroeder_reverb: assertion failed");
`else
`define SR_ASSERT_IMP(lbl, ante, cons)
`define SR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/schrev_pkg.sv =====
// Types, constants and arithmetic helpers of the reverberator.
package schrev_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int INT_W     = 28;
	localparam int WIDE_W    = INT_W + 2;
	localparam int GAIN_W    = 15;
	localparam int PROD_W    = INT_W + GAIN_W + 1;
	localparam int SCALED_W  = PROD_W - GAIN_W;
	localparam int CFG_IDX_W = 3;

	// pipeline map (top-level stage numbers)
	localparam int AVG_STAGE     = 4;
	localparam int AP_STAGES     = 5;
	localparam int AP_A_FIRST    = 5;
	localparam int AP_B_FIRST    = AP_A_FIRST + AP_STAGES;
	localparam int NUM_STAGES    = AP_B_FIRST + AP_STAGES;
	localparam int LAST_WR_STAGE = AP_B_FIRST + 1;
	localparam int CNT_W         = $clog2(LAST_WR_STAGE + 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [INT_W-1:0]    int_t;
	typedef logic signed [WIDE_W-1:0]   wide_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [SCALED_W-1:0] scaled_t;
	typedef logic [GAIN_W-1:0]          gain_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COMB_GAIN_A    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMB_GAIN_B    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COMB_GAIN_C    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COMB_GAIN_D    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALLPASS_GAIN_A = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ALLPASS_GAIN_B = 3'd5;

	localparam gain_t COMB_GAIN_A_RST    = 15'd26690;
	localparam gain_t COMB_GAIN_B_RST    = 15'd25360;
	localparam gain_t COMB_GAIN_C_RST    = 15'd24669;
	localparam gain_t COMB_GAIN_D_RST    = 15'd24230;
	localparam gain_t ALLPASS_GAIN_A_RST = 15'd22938;
	localparam gain_t ALLPASS_GAIN_B_RST = 15'd22938;

	localparam int_t    INT_MAX   = {1'b0, {(INT_W-1){1'b1}}};
	localparam int_t    INT_MIN   = {1'b1, {(INT_W-1){1'b0}}};
	localparam sample_t OUT_MAX   = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t OUT_MIN   = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam prod_t   ROUND_ADD = prod_t'(1) <<< (GAIN_W - 1);
	localparam wide_t   AVG_ROUND = wide_t'(2);

	// control of one comb lane
	typedef struct packed {
		logic ld1;   // stage 1 (line read data) loads
		logic step;  // new request enters: advance position
		logic ld2;
		logic ld3;
		logic wr;    // comb output written back to the line
	} comb_ctl_t;

	// control of one allpass section, local stages 1..AP_STAGES
	typedef struct packed {
		logic [AP_STAGES-1:0] ld;
		logic                 step;
		logic                 wr;
	} ap_ctl_t;

	// exact Q0.15 gain product
	function automatic prod_t gain_prod(gain_t g, int_t s);
		logic signed [GAIN_W:0] gs;
		gs = $signed({1'b0, g});
		return prod_t'(gs * s);
	endfunction

	// (p + half) >>> 15
	function automatic scaled_t scale_down(prod_t p);
		prod_t t;
		t = p + ROUND_ADD;
		return t[PROD_W-1:GAIN_W];
	endfunction

	function automatic int_t sat_int(wide_t v);
		if (&v[WIDE_W-1:INT_W-1] || !(|v[WIDE_W-1:INT_W-1]))
			return v[INT_W-1:0];
		else if (v[WIDE_W-1])
			return INT_MIN;
		else
			return INT_MAX;
	endfunction

	function automatic sample_t sat_out(int_t v);
		if (&v[INT_W-1:SAMPLE_W-1] || !(|v[INT_W-1:SAMPLE_W-1]))
			return v[SAMPLE_W-1:0];
		else if (v[INT_W-1])
			return OUT_MIN;
		else
			return OUT_MAX;
	endfunction

endpackage

// ===== sv/schrev_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
module schrev_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/schrev_comb.sv =====
// One feedback comb lane: delay line, gain multiply, add and saturate.
module schrev_comb #(
	parameter int DEPTH = 1217,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  schrev_pkg::comb_ctl_t ctl,
	input  logic                  clr_en,
	input  logic [AW-1:0]         clr_addr,
	input  schrev_pkg::gain_t     gain,
	input  schrev_pkg::sample_t   x_s2,
	output schrev_pkg::int_t      y_s3
);

	import schrev_pkg::*;

	logic [AW-1:0] pos_q;
	logic [AW-1:0] addr_s1, addr_s2;
	int_t          d_s1;
	prod_t         prod_s2;
	int_t          y_next;

	assign y_next = sat_int(wide_t'(x_s2) + wide_t'(scale_down(prod_s2)));

	schrev_ram #(.WIDTH(INT_W), .DEPTH(DEPTH)) u_line (
		.clk   (clk),
		.we    (clr_en | ctl.wr),
		.waddr (clr_en ? clr_addr : addr_s2),
		.wdata (clr_en ? '0 : y_next),
		.re    (ctl.ld1),
		.raddr (pos_q),
		.rdata (d_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctl.step) begin
			pos_q <= (pos_q == AW'(DEPTH - 1)) ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld1)
			addr_s1 <= pos_q;
		if (ctl.ld2) begin
			addr_s2 <= addr_s1;
			prod_s2 <= gain_prod(gain, d_s1);
		end
		if (ctl.ld3)
			y_s3 <= y_next;
	end

endmodule

// ===== sv/schrev_allpass.sv =====
// One allpass section: node line, two gain multiplies, local stages 1..5.
module schrev_allpass #(
	parameter int DEPTH = 205,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  schrev_pkg::ap_ctl_t ctl,
	input  logic                clr_en,
	input  logic [AW-1:0]       clr_addr,
	input  schrev_pkg::gain_t   gain,
	input  schrev_pkg::int_t    x_in,
	output schrev_pkg::int_t    y_s5
);

	import schrev_pkg::*;

	logic [AW-1:0] pos_q;
	logic [AW-1:0] addr_s1, addr_s2;
	int_t          x_s1, x_s2;
	int_t          d_s1, d_s2, d_s3, d_s4;
	prod_t         prod_s2, prod_s4;
	int_t          w_s3;
	int_t          w_next;

	// w = x - g*d, node written back to the line
	assign w_next = sat_int(wide_t'(x_s2) - wide_t'(scale_down(prod_s2)));

	schrev_ram #(.WIDTH(INT_W), .DEPTH(DEPTH)) u_line (
		.clk   (clk),
		.we    (clr_en | ctl.wr),
		.waddr (clr_en ? clr_addr : addr_s2),
		.wdata (clr_en ? '0 : w_next),
		.re    (ctl.ld[0]),
		.raddr (pos_q),
		.rdata (d_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctl.step) begin
			pos_q <= (pos_q == AW'(DEPTH - 1)) ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[0]) begin
			x_s1    <= x_in;
			addr_s1 <= pos_q;
		end
		if (ctl.ld[1]) begin
			x_s2    <= x_s1;
			d_s2    <= d_s1;
			addr_s2 <= addr_s1;
			prod_s2 <= gain_prod(gain, d_s1);
		end
		if (ctl.ld[2]) begin
			w_s3 <= w_next;
			d_s3 <= d_s2;
		end
		if (ctl.ld[3]) begin
			prod_s4 <= gain_prod(gain, w_s3);
			d_s4    <= d_s3;
		end
		// y = g*w + d
		if (ctl.ld[4])
			y_s5 <= sat_int(wide_t'(scale_down(prod_s4)) + wide_t'(d_s4));
	end

endmodule

// ===== sv/schroeder_reverb.sv =====
// Top level of the Schroeder reverberator: four combs, two allpass sections.
//
//  channel | signals                                 | moves
//  --------+-----------------------------------------+-------------------------------
//  input   | in_valid, in_stall, in_sample           | one 24-bit sample request
//  output  | out_valid, out_stall, out_sample        | one 24-bit reverberated sample
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | one gain register write
//
//  One request is taken per cycle while stage 1 can move on and fewer requests
//  than the shortest delay line are still in stages 1..11 (the last line write,
//  allpass B, leaves stage 11).
//  After reset a clearing pass zeroes all six lines, one entry a cycle, over
//  every address of the longest line (1790 entries with the default delays);
//  input is stalled meanwhile, configuration writes are taken as ever.
//  Each stage has its own valid bit and a ready chain: a stall on the output
//  holds only the stages that are full, bubbles close up behind it.
module schroeder_reverb #(
	parameter int COMB_DELAY_A    = 1217,
	parameter int COMB_DELAY_B    = 1520,
	parameter int COMB_DELAY_C    = 1683,
	parameter int COMB_DELAY_D    = 1790,
	parameter int ALLPASS_DELAY_A = 205,
	parameter int ALLPASS_DELAY_B = 70
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample requests in
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  schrev_pkg::sample_t                  in_sample,
	// reverberated samples out
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output schrev_pkg::sample_t                  out_sample,
	// register writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [schrev_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  schrev_pkg::gain_t                    cfg_data
);

	import schrev_pkg::*;

	// line geometry
	localparam int MAX_C01 = (COMB_DELAY_A > COMB_DELAY_B) ? COMB_DELAY_A : COMB_DELAY_B;
	localparam int MAX_C23 = (COMB_DELAY_C > COMB_DELAY_D) ? COMB_DELAY_C : COMB_DELAY_D;
	localparam int MAX_C   = (MAX_C01 > MAX_C23) ? MAX_C01 : MAX_C23;
	localparam int MAX_AP  = (ALLPASS_DELAY_A > ALLPASS_DELAY_B) ?
	                         ALLPASS_DELAY_A : ALLPASS_DELAY_B;
	localparam int MAX_D   = (MAX_C > MAX_AP) ? MAX_C : MAX_AP;
	localparam int MIN_C01 = (COMB_DELAY_A < COMB_DELAY_B) ? COMB_DELAY_A : COMB_DELAY_B;
	localparam int MIN_C23 = (COMB_DELAY_C < COMB_DELAY_D) ? COMB_DELAY_C : COMB_DELAY_D;
	localparam int MIN_C   = (MIN_C01 < MIN_C23) ? MIN_C01 : MIN_C23;
	localparam int MIN_AP  = (ALLPASS_DELAY_A < ALLPASS_DELAY_B) ?
	                         ALLPASS_DELAY_A : ALLPASS_DELAY_B;
	localparam int MIN_D   = (MIN_C < MIN_AP) ? MIN_C : MIN_AP;
	localparam int CLR_W   = $clog2(MAX_D + 1);

	localparam int AW_CA = (COMB_DELAY_A > 1) ? $clog2(COMB_DELAY_A) : 1;
	localparam int AW_CB = (COMB_DELAY_B > 1) ? $clog2(COMB_DELAY_B) : 1;
	localparam int AW_CC = (COMB_DELAY_C > 1) ? $clog2(COMB_DELAY_C) : 1;
	localparam int AW_CD = (COMB_DELAY_D > 1) ? $clog2(COMB_DELAY_D) : 1;
	localparam int AW_AA = (ALLPASS_DELAY_A > 1) ? $clog2(ALLPASS_DELAY_A) : 1;
	localparam int AW_AB = (ALLPASS_DELAY_B > 1) ? $clog2(ALLPASS_DELAY_B) : 1;

	// gain registers
	gain_t comb_gain_a_q, comb_gain_b_q, comb_gain_c_q, comb_gain_d_q;
	gain_t allpass_gain_a_q, allpass_gain_b_q;

	// pipeline control
	logic [NUM_STAGES:1] v_q;
	logic [NUM_STAGES:1] rdy;
	logic                accept;
	logic                line_done;
	logic [CNT_W-1:0]    cnt_q;

	// clearing pass
	logic             clr_active_q;
	logic [CLR_W-1:0] clr_addr_q;

	// datapath
	sample_t   x_s1, x_s2;
	int_t      comb_a_y, comb_b_y, comb_c_y, comb_d_y;
	wide_t     comb_sum;
	int_t      avg_s4;
	int_t      ap_a_y, ap_b_y;
	sample_t   out_s15;
	comb_ctl_t comb_ctl;
	ap_ctl_t   ap_a_ctl, ap_b_ctl;

	//--------------------------------------------------------------------
	// Handshake and ready chain
	//--------------------------------------------------------------------
	assign rdy[NUM_STAGES] = !v_q[NUM_STAGES] || !out_stall;

	for (genvar k = 1; k < NUM_STAGES; k++) begin : g_rdy
		assign rdy[k] = !v_q[k] || rdy[k+1];
	end

	// A request may only enter once the request one line length back has
	// finished all its line writes, so no read ever overtakes its write.
	assign in_stall  = !rdy[1] || clr_active_q || (int'(cnt_q) >= MIN_D);
	assign accept    = in_valid && !in_stall;
	assign line_done = v_q[LAST_WR_STAGE] && rdy[LAST_WR_STAGE+1];

	assign out_valid  = v_q[NUM_STAGES];
	assign out_sample = out_s15;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			cnt_q <= '0;
		end else begin
			if (rdy[1])
				v_q[1] <= accept;
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (rdy[k])
					v_q[k] <= v_q[k-1];
			end
			if (accept && !line_done)
				cnt_q <= cnt_q + 1'b1;
			else if (!accept && line_done)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	//--------------------------------------------------------------------
	// Clearing pass over all lines after reset
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == CLR_W'(MAX_D - 1))
				clr_active_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	//--------------------------------------------------------------------
	// Gain registers
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comb_gain_a_q    <= COMB_GAIN_A_RST;
			comb_gain_b_q    <= COMB_GAIN_B_RST;
			comb_gain_c_q    <= COMB_GAIN_C_RST;
			comb_gain_d_q    <= COMB_GAIN_D_RST;
			allpass_gain_a_q <= ALLPASS_GAIN_A_RST;
			allpass_gain_b_q <= ALLPASS_GAIN_B_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COMB_GAIN_A:    comb_gain_a_q    <= cfg_data;
				REG_COMB_GAIN_B:    comb_gain_b_q    <= cfg_data;
				REG_COMB_GAIN_C:    comb_gain_c_q    <= cfg_data;
				REG_COMB_GAIN_D:    comb_gain_d_q    <= cfg_data;
				REG_ALLPASS_GAIN_A: allpass_gain_a_q <= cfg_data;
				REG_ALLPASS_GAIN_B: allpass_gain_b_q <= cfg_data;
				default: ;  // unknown index: write dropped
			endcase
		end
	end

	//--------------------------------------------------------------------
	// Stages 1..3: four combs in parallel
	//--------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (rdy[1])
			x_s1 <= in_sample;
		if (rdy[2])
			x_s2 <= x_s1;
	end

	assign comb_ctl.ld1  = rdy[1];
	assign comb_ctl.step = accept;
	assign comb_ctl.ld2  = rdy[2];
	assign comb_ctl.ld3  = rdy[3];
	assign comb_ctl.wr   = v_q[2] && rdy[3];

	schrev_comb #(.DEPTH(COMB_DELAY_A)) u_comb_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (comb_ctl),
		.clr_en   (clr_active_q && (clr_addr_q < CLR_W'(COMB_DELAY_A))),
		.clr_addr (clr_addr_q[AW_CA-1:0]),
		.gain     (comb_gain_a_q),
		.x_s2     (x_s2),
		.y_s3     (comb_a_y)
	);

	schrev_comb #(.DEPTH(COMB_DELAY_B)) u_comb_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (comb_ctl),
		.clr_en   (clr_active_q && (clr_addr_q < CLR_W'(COMB_DELAY_B))),
		.clr_addr (clr_addr_q[AW_CB-1:0]),
		.gain     (comb_gain_b_q),
		.x_s2     (x_s2),
		.y_s3     (comb_b_y)
	);

	schrev_comb #(.DEPTH(COMB_DELAY_C)) u_comb_c (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (comb_ctl),
		.clr_en   (clr_active_q && (clr_addr_q < CLR_W'(COMB_DELAY_C))),
		.clr_addr (clr_addr_q[AW_CC-1:0]),
		.gain     (comb_gain_c_q),
		.x_s2     (x_s2),
		.y_s3     (comb_c_y)
	);

	schrev_comb #(.DEPTH(COMB_DELAY_D)) u_comb_d (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (comb_ctl),
		.clr_en   (clr_active_q && (clr_addr_q < CLR_W'(COMB_DELAY_D))),
		.clr_addr (clr_addr_q[AW_CD-1:0]),
		.gain     (comb_gain_d_q),
		.x_s2     (x_s2),
		.y_s3     (comb_d_y)
	);

	//--------------------------------------------------------------------
	// Stage 4: rounded average of the combs, (sum + 2) >>> 2
	//--------------------------------------------------------------------
	assign comb_sum = wide_t'(comb_a_y) + wide_t'(comb_b_y) + wide_t'(comb_c_y)
	                + wide_t'(comb_d_y) + AVG_ROUND;

	always_ff @(posedge clk) begin
		if (rdy[AVG_STAGE])
			avg_s4 <= comb_sum[WIDE_W-1:2];
	end

	//--------------------------------------------------------------------
	// Stages 5..9: allpass A, stages 10..14: allpass B
	//--------------------------------------------------------------------
	assign ap_a_ctl.ld   = rdy[AP_A_FIRST+AP_STAGES-1:AP_A_FIRST];
	assign ap_a_ctl.step = v_q[AP_A_FIRST-1] && rdy[AP_A_FIRST];
	assign ap_a_ctl.wr   = v_q[AP_A_FIRST+1] && rdy[AP_A_FIRST+2];

	assign ap_b_ctl.ld   = rdy[AP_B_FIRST+AP_STAGES-1:AP_B_FIRST];
	assign ap_b_ctl.step = v_q[AP_B_FIRST-1] && rdy[AP_B_FIRST];
	assign ap_b_ctl.wr   = v_q[AP_B_FIRST+1] && rdy[AP_B_FIRST+2];

	schrev_allpass #(.DEPTH(ALLPASS_DELAY_A)) u_ap_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ap_a_ctl),
		.clr_en   (clr_active_q && (clr_addr_q < CLR_W'(ALLPASS_DELAY_A))),
		.clr_addr (clr_addr_q[AW_AA-1:0]),
		.gain     (allpass_gain_a_q),
		.x_in     (avg_s4),
		.y_s5     (ap_a_y)
	);

	schrev_allpass #(.DEPTH(ALLPASS_DELAY_B)) u_ap_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ap_b_ctl),
		.clr_en   (clr_active_q && (clr_addr_q < CLR_W'(ALLPASS_DELAY_B))),
		.clr_addr (clr_addr_q[AW_AB-1:0]),
		.gain     (allpass_gain_b_q),
		.x_in     (ap_a_y),
		.y_s5     (ap_b_y)
	);

	//--------------------------------------------------------------------
	// Stage 15: output register, saturated to 24 bits
	//--------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (rdy[NUM_STAGES])
			out_s15 <= sat_out(ap_b_y);
	end

	//--------------------------------------------------------------------
	// Checks
	//--------------------------------------------------------------------
`include "schroeder_reverb_defines.svh"

	// in-flight count matches the valid bits ahead of the last line write
	`SR_ASSERT_IMP(a_cnt_tracks_valid, 1'b1, int'(cnt_q) == $countones(v_q[LAST_WR_STAGE:1]))
	// nothing travels the pipe while the lines are being cleared
	`SR_ASSERT_IMP(a_empty_while_clr, clr_active_q, v_q == '0)
	// an accepted request always lands in stage 1
	`SR_ASSERT_NXT(a_accept_lands, accept, v_q[1])
	// the hazard guard never lets more requests in than the shortest line
	`SR_ASSERT_IMP(a_cnt_bounded, 1'b1, int'(cnt_q) <= MIN_D)

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the Schroeder reverberator: directed, saturation, back-pressure and random runs.
`timescale 1ns / 100ps

module tb;
	import schrev_pkg::*;

	// delay line depths, passed to the block so that the shadow lines match
	localparam int COMB_DELAY_A    = 1217;
	localparam int COMB_DELAY_B    = 1520;
	localparam int COMB_DELAY_C    = 1683;
	localparam int COMB_DELAY_D    = 1790;
	localparam int ALLPASS_DELAY_A = 205;
	localparam int ALLPASS_DELAY_B = 70;

	localparam int LINE_COUNT      = 6;
	localparam int MAX_DEPTH       = 2048;
	localparam int DRAIN_CYCLES    = 24;    // pipeline is 15 deep, plus margin
	localparam int WATCHDOG_LIMIT  = 8000;  // covers the clearing pass over the longest line
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int ERR_PRINT_LIMIT = 40;
	localparam int PHASE_ITEMS     = 400;

	localparam gain_t GAIN_MAX  = '1;
	localparam gain_t GAIN_ZERO = '0;
	localparam gain_t GAIN_HALF = 15'd16384;
	localparam gain_t GAIN_LSB  = 15'd1;

	// indexes beyond the register file; writes to them must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam longint INT_LO = INT_MIN;
	localparam longint INT_HI = INT_MAX;
	localparam longint OUT_LO = OUT_MIN;
	localparam longint OUT_HI = OUT_MAX;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	sample_t              in_sample;
	logic                 out_valid;
	logic                 out_stall;
	sample_t              out_sample;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	gain_t                cfg_data;

	// shadow of the block: gain registers, six delay lines and their positions
	gain_t   gain_shadow [LINE_COUNT];
	int_t    line_mem    [LINE_COUNT][MAX_DEPTH];
	int      line_pos    [LINE_COUNT];

	sample_t    pending_out_q [$];  // predicted samples, oldest first
	sample_t    last_sample = '0;
	idle_mode_e idle_mode   = IDLE_NONE;
	int         hold_cycles = 0;    // receiver hold-off, counted down below
	int         err_count   = 0;
	int         out_seen    = 0;

	schroeder_reverb #(
		.COMB_DELAY_A   (COMB_DELAY_A),
		.COMB_DELAY_B   (COMB_DELAY_B),
		.COMB_DELAY_C   (COMB_DELAY_C),
		.COMB_DELAY_D   (COMB_DELAY_D),
		.ALLPASS_DELAY_A(ALLPASS_DELAY_A),
		.ALLPASS_DELAY_B(ALLPASS_DELAY_B)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_sample (in_sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_sample(out_sample),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// lines 0..3 are the combs, 4 and 5 the allpass sections; the gain
	// register with the same index belongs to each line
	function automatic int line_depth(int k);
		case (k)
			0: return COMB_DELAY_A;
			1: return COMB_DELAY_B;
			2: return COMB_DELAY_C;
			3: return COMB_DELAY_D;
			4: return ALLPASS_DELAY_A;
			default: return ALLPASS_DELAY_B;
		endcase
	endfunction

	// Q0.15 product, rounded half up by the floor shift
	function automatic longint gain_scale(gain_t g, longint s);
		longint p;
		p = longint'(g) * s + (longint'(1) <<< (GAIN_W - 1));
		return p >>> GAIN_W;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic longint line_tap(int k);
		return longint'(line_mem[k][line_pos[k]]);
	endfunction

	// overwrite the entry just read, then step on with wrap
	function automatic void line_push(int k, longint v);
		line_mem[k][line_pos[k]] = int_t'(v);
		line_pos[k] = (line_pos[k] + 1 >= line_depth(k)) ? 0 : line_pos[k] + 1;
	endfunction

	// one sample through four combs, the average and both allpass sections
	function automatic sample_t reverb_predict(sample_t x);
		longint comb_sum;
		longint node;
		longint tap;
		longint y;
		comb_sum = 0;
		for (int k = 0; k < 4; k++) begin
			y = clip(longint'(x) + gain_scale(gain_shadow[k], line_tap(k)), INT_LO, INT_HI);
			line_push(k, y);
			comb_sum += y;
		end
		y = (comb_sum + 2) >>> 2;
		for (int k = 4; k < LINE_COUNT; k++) begin
			tap  = line_tap(k);
			node = clip(y - gain_scale(gain_shadow[k], tap), INT_LO, INT_HI);
			y    = clip(gain_scale(gain_shadow[k], node) + tap, INT_LO, INT_HI);
			line_push(k, node);
		end
		return sample_t'(clip(y, OUT_LO, OUT_HI));
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what);
		if (err_count < ERR_PRINT_LIMIT)
			$display("%0t ns: mismatch: %s", $time, what);
		err_count++;
	endtask

	// every accepted output is matched against the oldest prediction
	always @(posedge clk) begin : check_out_sample
		sample_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_out_q.size() == 0) begin
				report_mismatch($sformatf("output %0d: %0d with nothing predicted",
					out_seen, out_sample));
			end else begin
				due = pending_out_q.pop_front();
				if (out_sample !== due)
					report_mismatch($sformatf("output %0d: out_sample %0d, predicted %0d",
						out_seen, out_sample, due));
			end
			out_seen++;
		end
	end

	// the run ends if no request moves on any channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Idling
	// ------------------------------------------------------------------

	// chance in percent that a side idles in a given cycle
	function automatic int idle_pct(logic sender_side);
		case (idle_mode)
			IDLE_SENDER:   return sender_side ? 85 : 0;
			IDLE_RECEIVER: return sender_side ? 0 : 85;
			IDLE_BOTH:     return 6;
			default:       return 0;
		endcase
	endfunction

	// receiver: a pending hold-off wins over the random stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct(1'b0));
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offers one sample request, after a random gap, and predicts its output
	// once accepted. Valid stays high for a following request with no gap.
	task automatic send_sample(sample_t s);
		int gap;
		gap = 0;
		while (gap < 200 && $urandom_range(99) < idle_pct(1'b1))
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		in_sample <= s;
		do @(posedge clk); while (in_stall);
		pending_out_q.push_back(reverb_predict(s));
	endtask

	// sender pauses until every predicted sample has come out
	task automatic drain_output();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_out_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, gain_t val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_ALLPASS_GAIN_B)
			gain_shadow[idx] = val;
	endtask

	task automatic program_gains(gain_t ca, gain_t cb, gain_t cc, gain_t cd,
	                             gain_t aa, gain_t ab);
		write_reg(REG_COMB_GAIN_A, ca);
		write_reg(REG_COMB_GAIN_B, cb);
		write_reg(REG_COMB_GAIN_C, cc);
		write_reg(REG_COMB_GAIN_D, cd);
		write_reg(REG_ALLPASS_GAIN_A, aa);
		write_reg(REG_ALLPASS_GAIN_B, ab);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic gain_t rand_gain();
		return gain_t'($urandom_range(32767));
	endfunction

	// full-range noise, quiet noise, extremes and held values (low frequency)
	function automatic sample_t pick_sample();
		int r;
		r = $urandom_range(99);
		if (r < 50) begin
			last_sample = sample_t'($urandom);
		end else if (r < 70) begin
			last_sample = sample_t'(int'($urandom_range(511)) - 256);
		end else if (r < 85) begin
			case ($urandom_range(3))
				0: last_sample = OUT_MAX;
				1: last_sample = OUT_MIN;
				2: last_sample = '0;
				default: last_sample = '1;
			endcase
		end
		return last_sample;
	endfunction

	// near full-scale square wave; a half period equal to an allpass delay
	// makes that section's internal node grow by one amplitude per round
	task automatic drive_square(int half_period, int count);
		for (int i = 0; i < count; i++) begin
			if ((i / half_period) % 2 == 0)
				send_sample(OUT_MAX - sample_t'($urandom_range(255)));
			else
				send_sample(OUT_MIN + sample_t'($urandom_range(255)));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Register writes land during the clearing pass; spare indexes are
	// written to show they are ignored. Then sample extremes and bit patterns.
	task automatic test_directed_extremes();
		sample_t pattern [14];
		pattern = '{OUT_MAX, OUT_MIN, '0, '1, 24'sd1, OUT_MAX, OUT_MAX, OUT_MIN,
		            OUT_MIN, 24'h555555, 24'haaaaaa, 24'h800001, 24'h7ffffe, '0};
		idle_mode = IDLE_NONE;
		write_reg(REG_SPARE_6, GAIN_MAX);
		write_reg(REG_SPARE_7, rand_gain());
		program_gains(GAIN_MAX, GAIN_ZERO, GAIN_LSB, GAIN_HALF, GAIN_MAX, GAIN_ZERO);
		for (int i = 0; i < 14; i++)
			send_sample(pattern[i]);
		drain_output();
		write_reg(REG_SPARE_7, GAIN_ZERO);
		program_gains(GAIN_ZERO, GAIN_MAX, GAIN_HALF, GAIN_LSB, GAIN_ZERO, GAIN_MAX);
		for (int i = 0; i < 8; i++)
			send_sample(pattern[i]);
		drain_output();
	endtask

	// Near-unity comb feedback with a constant full-scale input: the
	// output saturates to 24 bits after a few thousand samples, and comb A
	// reaches the 28-bit limit after about 17 rounds of its delay.
	task automatic test_comb_saturation();
		program_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_ZERO, GAIN_ZERO);
		idle_mode = IDLE_NONE;
		repeat (17 * COMB_DELAY_A + 500)
			send_sample(OUT_MAX - sample_t'($urandom_range(255)));
		drain_output();
	endtask

	// Allpass internal nodes driven into saturation of both signs, one
	// section at a time, with the other section reduced to a plain delay.
	task automatic test_allpass_saturation();
		idle_mode = IDLE_BOTH;
		program_gains(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_MAX, GAIN_ZERO);
		drive_square(ALLPASS_DELAY_A, 18 * ALLPASS_DELAY_A);
		drain_output();
		program_gains(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_MAX);
		drive_square(ALLPASS_DELAY_B, 22 * ALLPASS_DELAY_B);
		drain_output();
	endtask

	// Receiver holds off while requests keep coming, so the pipeline fills
	// and in_stall rises; afterwards the sender waits for a full drain.
	task automatic test_backpressure();
		program_gains(COMB_GAIN_A_RST, COMB_GAIN_B_RST, COMB_GAIN_C_RST, COMB_GAIN_D_RST,
		              ALLPASS_GAIN_A_RST, ALLPASS_GAIN_B_RST);
		idle_mode   = IDLE_NONE;
		hold_cycles = HOLD_OFF_CYCLES;
		repeat (120) send_sample(pick_sample());
		drain_output();
		repeat (60) send_sample(pick_sample());
		drain_output();
	endtask

	// Random samples in four idling phases, each with its own gains.
	task automatic test_random_phases();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					program_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
					              rand_gain(), rand_gain());
					idle_mode = IDLE_NONE;
				end
				1: begin
					program_gains(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO,
					              GAIN_ZERO, GAIN_ZERO);
					idle_mode = IDLE_SENDER;
				end
				2: begin
					program_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX,
					              GAIN_MAX, GAIN_MAX);
					idle_mode = IDLE_RECEIVER;
				end
				default: begin
					program_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
					              rand_gain(), rand_gain());
					idle_mode = IDLE_BOTH;
				end
			endcase
			repeat (PHASE_ITEMS) send_sample(pick_sample());
			drain_output();
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_sample <= '0;
		out_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_COMB_GAIN_A;
		cfg_data  <= '0;

		// shadow state after reset: lines cleared, gains at their defaults
		for (int k = 0; k < LINE_COUNT; k++) begin
			line_pos[k] = 0;
			for (int j = 0; j < MAX_DEPTH; j++)
				line_mem[k][j] = '0;
		end
		gain_shadow[REG_COMB_GAIN_A]    = COMB_GAIN_A_RST;
		gain_shadow[REG_COMB_GAIN_B]    = COMB_GAIN_B_RST;
		gain_shadow[REG_COMB_GAIN_C]    = COMB_GAIN_C_RST;
		gain_shadow[REG_COMB_GAIN_D]    = COMB_GAIN_D_RST;
		gain_shadow[REG_ALLPASS_GAIN_A] = ALLPASS_GAIN_A_RST;
		gain_shadow[REG_ALLPASS_GAIN_B] = ALLPASS_GAIN_B_RST;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_extremes();
		test_backpressure();
		test_comb_saturation();
		test_allpass_saturation();
		test_random_phases();

		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/schrev_pkg.sv
sv/schrev_ram.sv
sv/schrev_comb.sv
sv/schrev_allpass.sv
sv/schroeder_reverb.sv
dv/tb.sv
